// ----- sv/b2da_pkg.sv -----
`default_nettype none

package b2da_pkg;

  // Largest number of decimal digits a conversion can produce.
  localparam int unsigned MaxDigits = 16;
  // Width of the binary input word.
  localparam int unsigned ValueW = 32;
  // Width of the requested digit count.
  localparam int unsigned CountW = 5;
  // Width of an emitted character.
  localparam int unsigned CharW = 6;
  // Width of a digit position index.
  localparam int unsigned DigitW = $clog2(MaxDigits);
  // Width of the double-dabble bit counter.
  localparam int unsigned BitCntW = $clog2(ValueW);
  // Number of words the queue between front and back can hold.
  localparam int unsigned QueueDepth = 2;

  // ASCII code of the character '0', truncated to the character width.
  localparam logic [CharW-1:0] AsciiZero = CharW'(48);
  // Digits at or above this value get the add-3 correction before a shift.
  localparam logic [3:0] DabbleLimit = 4'd5;
  localparam logic [3:0] DabbleAdd = 4'd3;

  // Conversion modes as carried in the cmd field.
  typedef enum logic {
    ModeFixed    = 1'b0,
    ModeSuppress = 1'b1
  } mode_e;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    mode_e              mode;
    logic [ValueW-1:0]  value;
    logic [DigitW-1:0]  top_pos;
  } entry_t;

endpackage

`default_nettype wire

// ----- sv/b2da_front.sv -----
`default_nettype none

module b2da_front (
  input  wire logic                          start,
  input  wire logic                          full_i,
  input  wire logic                          cmd_i,
  input  wire logic [b2da_pkg::ValueW-1:0]   value_i,
  input  wire logic [b2da_pkg::CountW-1:0]   digit_count_i,
  output logic                               push_o,
  output b2da_pkg::entry_t                   entry_o
);
  import b2da_pkg::*;

  logic [DigitW-1:0] fixed_pos;

  // A word is taken whenever the queue has room.
  assign push_o = start & ~full_i;

  // In fixed mode the top digit position follows from the clamped count.
  always_comb begin
    if (int'(digit_count_i) > int'(MaxDigits)) begin
      fixed_pos = DigitW'(MaxDigits - 1);
    end else if (digit_count_i == '0) begin
      fixed_pos = '0;
    end else begin
      fixed_pos = DigitW'(digit_count_i - CountW'(1));
    end
  end

  // Suppress mode starts its leading-zero scan from the highest position.
  always_comb begin
    entry_o.mode  = mode_e'(cmd_i);
    entry_o.value = value_i;
    if (mode_e'(cmd_i) == ModeSuppress) begin
      entry_o.top_pos = DigitW'(MaxDigits - 1);
    end else begin
      entry_o.top_pos = fixed_pos;
    end
  end

endmodule

`default_nettype wire

// ----- sv/b2da_queue.sv -----
`default_nettype none

module b2da_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire b2da_pkg::entry_t  entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output b2da_pkg::entry_t       entry_o
);
  import b2da_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            slot_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign entry_o = slot_q[rd_ptr_q];

  // Pointer and fill count update; push and pop may share a cycle.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots hold payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/b2da_back.sv -----
`default_nettype none

module b2da_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          empty_i,
  input  wire b2da_pkg::entry_t              entry_i,
  output logic                               pop_o,
  output logic                               strobe_o,
  output logic [b2da_pkg::CharW-1:0]         character_o,
  output logic                               last_o
);
  import b2da_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StScan = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  mode_e                        mode_q, mode_d;
  logic [ValueW-1:0]            val_q, val_d;
  logic [MaxDigits-1:0][3:0]    bcd_q, bcd_d;
  logic [MaxDigits-1:0][3:0]    bcd_adj;
  logic [4*MaxDigits-1:0]       bcd_adj_bits;
  logic [BitCntW-1:0]           bit_cnt_q, bit_cnt_d;
  logic [DigitW-1:0]            pos_q, pos_d;
  logic [3:0]                   cur_digit;
  logic                         strobe_d, last_d;
  logic [CharW-1:0]             char_q, char_d;
  logic                         strobe_q, last_q;

  assign cur_digit = bcd_q[pos_q];
  assign pop_o     = (state_q == StIdle) && !empty_i;

  // Add-3 correction on every digit ahead of the next shift.
  always_comb begin
    for (int i = 0; i < int'(MaxDigits); i++) begin
      bcd_adj[i] = (bcd_q[i] >= DabbleLimit) ? bcd_q[i] + DabbleAdd : bcd_q[i];
    end
  end

  // Flat view of the corrected digits for the one-bit shift.
  assign bcd_adj_bits = bcd_adj;

  // Sequencer: load, shift-add-3 over every input bit, skip leading zeros, emit.
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    val_d     = val_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    pos_d     = pos_q;
    strobe_d  = 1'b0;
    last_d    = 1'b0;
    char_d    = char_q;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          mode_d    = entry_i.mode;
          val_d     = entry_i.value;
          pos_d     = entry_i.top_pos;
          bcd_d     = '0;
          bit_cnt_d = '0;
          state_d   = StConv;
        end
      end
      StConv: begin
        bcd_d     = {bcd_adj_bits[4*MaxDigits-2:0], val_q[ValueW-1]};
        val_d     = {val_q[ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + BitCntW'(1);
        if (bit_cnt_q == BitCntW'(ValueW - 1)) begin
          state_d = (mode_q == ModeSuppress) ? StScan : StEmit;
        end
      end
      StScan: begin
        if ((pos_q != '0) && (cur_digit == '0)) begin
          pos_d = pos_q - DigitW'(1);
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        strobe_d = 1'b1;
        char_d   = AsciiZero + CharW'(cur_digit);
        last_d   = (pos_q == '0);
        if (pos_q == '0) begin
          state_d = StIdle;
        end else begin
          pos_d = pos_q - DigitW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    val_q     <= val_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    pos_q     <= pos_d;
    char_q    <= char_d;
  end

  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ----- sv/binary_to_decimal_ascii_core.sv -----
// Each accepted word yields its characters one per cycle on consecutive cycles.
// The first character follows the 32-step shift-add-3 loop and, in suppress mode, the
// scan that skips leading zeros.
// The converter takes a new word from the queue only after the previous word is emitted.
// A two-word queue takes new words while the converter works; busy is its full flag.
// Reset is asynchronous and active low; it empties the queue and idles the converter.
`default_nettype none

module binary_to_decimal_ascii_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cmd_i,
  input  wire logic [b2da_pkg::ValueW-1:0]   value_i,
  input  wire logic [b2da_pkg::CountW-1:0]   digit_count_i,
  output logic                               strobe_o,
  output logic [b2da_pkg::CharW-1:0]         character_o,
  output logic                               last_o
);
  import b2da_pkg::*;

  logic    push, pop, full, empty;
  entry_t  front_entry, queue_entry;

  assign busy = full;

  // Front: accept and classify each word.
  b2da_front u_front (
    .start         (start),
    .full_i        (full),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  // Queue between front and back.
  b2da_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (queue_entry)
  );

  // Back: convert and emit characters.
  b2da_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (queue_entry),
    .pop_o       (pop),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ----- sv/b2da_checker.sv -----
`default_nettype none

module b2da_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          strobe_o,
  input  wire logic [b2da_pkg::CharW-1:0]    character_o,
  input  wire logic                          last_o
);
  import b2da_pkg::*;

  // Every emitted character is a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (character_o >= AsciiZero) && (character_o <= AsciiZero + CharW'(9)))
    else $error("character outside of the decimal digits");

  // The last flag only appears together with a character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o)
    else $error("last flag without a character");

  // Characters of one word come on consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |=> strobe_o)
    else $error("gap inside a word");

  // A new word cannot begin right after the last character of the previous one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> !strobe_o)
    else $error("character directly after the end of a word");

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .strobe_o    (strobe_o),
  .character_o (character_o),
  .last_o      (last_o)
);

`default_nettype wire

// ----- verif/tb_binary_to_decimal_ascii_core.sv -----
`default_nettype none

module tb_binary_to_decimal_ascii_core;
  import b2da_pkg::*;

  // Cycle limit for the whole run; this leaves a wide margin over a clean run.
  localparam int unsigned CycleLimit = 400000;
  // Cycles to keep watching the outputs once nothing is expected any more.
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned RandomWords = 400;

  // Tracks the characters still owed by the converter, oldest first.
  class digit_scoreboard;
    typedef struct {
      logic [CharW-1:0] character;
      logic             last;
    } char_t;

    char_t       owed_chars[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    // Works out the characters that one accepted word produces.
    function void note_word(mode_e mode, logic [ValueW-1:0] value,
                            logic [CountW-1:0] count);
      logic [3:0]        digits [MaxDigits];
      logic [ValueW-1:0] rest;
      int                width;
      char_t             c;
      rest = value;
      for (int i = 0; i < MaxDigits; i++) begin
        digits[i] = 4'(rest % 10);
        rest = rest / 10;
      end
      if (mode == ModeFixed) begin
        if (count == 0) width = 1;
        else if (count > MaxDigits) width = MaxDigits;
        else width = int'(count);
      end else begin
        // Width follows the highest nonzero digit; zero still gives one digit.
        width = 1;
        for (int i = 0; i < MaxDigits; i++) begin
          if (digits[i] != 0) width = i + 1;
        end
      end
      for (int i = width - 1; i >= 0; i--) begin
        c.character = AsciiZero + CharW'(digits[i]);
        c.last = (i == 0);
        owed_chars.push_back(c);
      end
    endfunction

    // Compares one emitted character with the oldest one owed.
    function void check_char(logic [CharW-1:0] character, logic last);
      char_t c;
      if (owed_chars.size() == 0) begin
        $error("unexpected character %0d (last %0d)", character, last);
        fail_count++;
        return;
      end
      c = owed_chars.pop_front();
      if (character !== c.character) begin
        $error("character: expected %0d, actual %0d", c.character, character);
        fail_count++;
      end
      if (last !== c.last) begin
        $error("last: expected %0d, actual %0d", c.last, last);
        fail_count++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              cmd_i = 1'b0;
  logic [ValueW-1:0] value_i = '0;
  logic [CountW-1:0] digit_count_i = '0;
  logic              strobe_o;
  logic [CharW-1:0]  character_o;
  logic              last_o;

  digit_scoreboard   sb = new();
  int unsigned       cycle_count = 0;
  int unsigned       idle_pct = 0;

  binary_to_decimal_ascii_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .strobe_o      (strobe_o),
    .character_o   (character_o),
    .last_o        (last_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Every strobed character is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.check_char(character_o, last_o);
    end
  end

  // Watchdog for a hung converter.
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("binary_to_decimal_ascii_core verification failed");
    $finish;
  end

  // Presents one word and returns at the edge where it is taken.
  task automatic send_word(mode_e mode, logic [ValueW-1:0] value,
                           logic [CountW-1:0] count);
    start <= 1'b1;
    cmd_i <= mode;
    value_i <= value;
    digit_count_i <= count;
    do @(posedge clk_i); while (busy);
    sb.note_word(mode, value, count);
  endtask

  // Drops start for a random run of cycles, per the current idle rate.
  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  task automatic send_and_gap(mode_e mode, logic [ValueW-1:0] value,
                              logic [CountW-1:0] count);
    send_word(mode, value, count);
    sender_gap();
  endtask

  // Values biased toward powers of ten, short numbers and the top of the range.
  function automatic logic [ValueW-1:0] random_value();
    logic [ValueW-1:0] p;
    p = 1;
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(31);
      2: begin
        repeat ($urandom_range(9)) p = p * 10;
        return p - 1 + $urandom_range(2);
      end
      default: return 32'hFFFF_FFFF - $urandom_range(1000);
    endcase
  endfunction

  initial begin
    logic [CountW-1:0] count;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: field extremes, both modes, count clamping, zero cases.
    send_and_gap(ModeFixed, 32'd0, 5'd0);
    send_and_gap(ModeFixed, 32'd7, 5'd0);
    send_and_gap(ModeFixed, 32'hFFFF_FFFF, 5'd1);
    send_and_gap(ModeFixed, 32'hFFFF_FFFF, 5'd10);
    send_and_gap(ModeFixed, 32'hFFFF_FFFF, 5'd16);
    send_and_gap(ModeFixed, 32'hFFFF_FFFF, 5'd17);
    send_and_gap(ModeFixed, 32'hFFFF_FFFF, 5'd31);
    send_and_gap(ModeFixed, 32'd1234567890, 5'd4);
    send_and_gap(ModeFixed, 32'd0, 5'd16);
    send_and_gap(ModeFixed, 32'd999999999, 5'd9);
    send_and_gap(ModeFixed, 32'd1000000000, 5'd9);
    send_and_gap(ModeSuppress, 32'd0, 5'd0);
    send_and_gap(ModeSuppress, 32'd0, 5'd31);
    send_and_gap(ModeSuppress, 32'd1, 5'd16);
    send_and_gap(ModeSuppress, 32'd9, 5'd3);
    send_and_gap(ModeSuppress, 32'd10, 5'd1);
    send_and_gap(ModeSuppress, 32'd1000000000, 5'd5);
    send_and_gap(ModeSuppress, 32'hFFFF_FFFF, 5'd31);
    send_and_gap(ModeSuppress, 32'h5555_5555, 5'd10);
    send_and_gap(ModeSuppress, 32'hAAAA_AAAA, 5'd21);

    // Random words in phases: no idling, heavy sender idling, light idling.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 63;
        default: idle_pct = 12;
      endcase
      for (int k = 0; k < RandomWords / 3; k++) begin
        // Counts mostly within the digit limit, sometimes beyond it.
        if ($urandom_range(9) < 8) count = CountW'($urandom_range(MaxDigits));
        else count = CountW'($urandom_range(31));
        send_and_gap(mode_e'($urandom_range(1)), random_value(), count);
      end
    end
    start <= 1'b0;

    // Wait for every owed character, then watch for stray ones.
    while (sb.owed_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.fail_count == 0 && sb.owed_chars.size() == 0) begin
      $display("binary_to_decimal_ascii_core verification clean");
    end else begin
      $display("binary_to_decimal_ascii_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
